// File: src/planar_tile_decode_dominant_color_macros.svh
// Assertion macros used by the checker file of the planar tile decoder.
// Depends on nothing; include by bare file name.
`ifndef PLANAR_TILE_DECODE_DOMINANT_COLOR_MACROS_SVH
`define PLANAR_TILE_DECODE_DOMINANT_COLOR_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PTDD_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ptdd assertion failed");

// Clocked assertion that is also checked during reset.
`define PTDD_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ptdd assertion failed");

`endif

// File: src/ptdd_pkg.sv
// Shared types, constants and helper functions of the planar tile decoder.
// Used by the top level and by its port checker.
package ptdd_pkg;

    localparam int TPS_DEFAULT = 16;

    localparam int PIX_W      = 32;
    localparam int NUM_PIX    = 8;
    localparam int OFFSET_W   = 14;
    localparam int TILE_W     = 8;
    localparam int ROW_W      = 3;
    localparam int TALLY_W    = 7;
    localparam int ROWCNT_W   = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W  = 16;
    // Output word layout, lowest bit first.
    localparam int OFFSET_LSB = NUM_PIX * PIX_W;
    localparam int PREF_LSB   = OFFSET_LSB + OFFSET_W;
    localparam int TILE_LSB   = PREF_LSB + 2;
    localparam int M_TDATA_W  = TILE_LSB + TILE_W;

    localparam logic [PIX_W-1:0] COLOR_ZERO_RST  = 32'hFF00_0000;
    localparam logic [PIX_W-1:0] COLOR_ONE_RST   = 32'hFF66_6666;
    localparam logic [PIX_W-1:0] COLOR_TWO_RST   = 32'hFFAA_AAAA;
    localparam logic [PIX_W-1:0] COLOR_THREE_RST = 32'hFFFF_FFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COLOR_ZERO,
        CFG_COLOR_ONE,
        CFG_COLOR_TWO,
        CFG_COLOR_THREE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CI_ZERO,
        CI_ONE,
        CI_TWO,
        CI_THREE
    } t_color_idx;

    // Integer division by three for tally values below 128: multiply by
    // 43/128, which stays exact over that range.
    function automatic logic [TALLY_W-1:0] div3(input logic [TALLY_W-1:0] v);
        logic [12:0] p;
        p = 13'(v) * 13'd43;
        return {1'b0, p[12:7]};
    endfunction

endpackage

// File: src/planar_tile_decode_dominant_color.sv
// One tile row in and 8 decoded ARGB pixels out, with the row's image offset,
// tile number and, on a tile's last row, its dominant color index. Each word
// passes an input register and then a result register, and a new word can enter
// every cycle while the output is not stalled;
// s_axis_tready follows m_axis_tready whenever the result register is full.
// The four palette registers should be written only while no word is in flight.
// TILES_PER_SIDE (1..64) sets the image width; offsets wrap at 14 bits.
module planar_tile_decode_dominant_color #(
    parameter int TILES_PER_SIDE = ptdd_pkg::TPS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [ptdd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ptdd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Row input: plane_low [7:0], plane_high [15:8].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ptdd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Result: pixel_a..pixel_h [255:0], image_offset [269:256],
    // preferred_color [271:270], tile_number [279:272].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ptdd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tile_done: last row of a tile.
    output logic                             m_axis_tlast
);
    import ptdd_pkg::*;

    localparam int TX_W   = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
    localparam int SIDE   = 8 * TILES_PER_SIDE;
    localparam int SIDE_W = $clog2(SIDE + 1);
    localparam int LINE_W = TILE_W + ROW_W;
    localparam int PROD_W = LINE_W + SIDE_W;

    logic                  w_adv;
    logic                  w_work;

    logic                  r_s1_valid;
    logic [7:0]            r_lo;
    logic [7:0]            r_hi;

    logic [PIX_W-1:0]      r_color_zero;
    logic [PIX_W-1:0]      r_color_one;
    logic [PIX_W-1:0]      r_color_two;
    logic [PIX_W-1:0]      r_color_three;

    logic [ROW_W-1:0]      r_row;
    logic [TILE_W-1:0]     r_tile;
    logic [TX_W-1:0]       r_tx;
    logic [TILE_W-1:0]     r_ty;
    logic [TALLY_W-1:0]    r_tally [4];

    logic [ROWCNT_W-1:0]   w_row_cnt [4];
    logic [TALLY_W-1:0]    w_sum [4];
    logic [TALLY_W-1:0]    w_c0_div3;
    logic [1:0]            w_pref;
    logic                  w_done;
    logic [LINE_W-1:0]     w_line;
    logic [PROD_W-1:0]     w_prod;
    logic [OFFSET_W-1:0]   w_offset;
    logic [NUM_PIX*PIX_W-1:0] w_pixels;

    logic                  r_m_valid;
    logic [M_TDATA_W-1:0]  r_tdata;
    logic                  r_tlast;

    function automatic logic [PIX_W-1:0] lookup(input logic [1:0] idx,
                                               input logic [PIX_W-1:0] c0,
                                               input logic [PIX_W-1:0] c1,
                                               input logic [PIX_W-1:0] c2,
                                               input logic [PIX_W-1:0] c3);
        logic [PIX_W-1:0] v;
        case (t_color_idx'(idx))
            CI_ZERO:  v = c0;
            CI_ONE:   v = c1;
            CI_TWO:   v = c2;
            CI_THREE: v = c3;
            default:  v = c0;
        endcase
        return v;
    endfunction

    assign w_adv         = !r_m_valid || m_axis_tready;
    assign w_work        = r_s1_valid && w_adv;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

    // Pixel decode and per-row color counts; column 0 comes from bit 7.
    always_comb begin
        logic [1:0] idx;
        for (int k = 0; k < 4; k++) begin
            w_row_cnt[k] = '0;
        end
        for (int c = 0; c < NUM_PIX; c++) begin
            idx = {r_hi[NUM_PIX-1-c], r_lo[NUM_PIX-1-c]};
            w_pixels[c*PIX_W +: PIX_W] = lookup(idx, r_color_zero, r_color_one,
                                                r_color_two, r_color_three);
            for (int k = 0; k < 4; k++) begin
                if (idx == 2'(k)) begin
                    w_row_cnt[k] = w_row_cnt[k] + ROWCNT_W'(1);
                end
            end
        end
        for (int k = 0; k < 4; k++) begin
            w_sum[k] = r_tally[k] + TALLY_W'(w_row_cnt[k]);
        end
    end

    // Dominant color over the tile, current row included.
    always_comb begin
        w_done    = (r_row == ROW_W'(7));
        w_c0_div3 = div3(w_sum[0]);
        if (w_sum[3] >= w_sum[1] && w_sum[3] >= w_sum[2] && w_sum[3] >= w_c0_div3) begin
            w_pref = CI_THREE;
        end else if (w_sum[2] >= w_sum[1] && w_sum[2] >= w_sum[3]
                     && w_sum[2] >= w_c0_div3) begin
            w_pref = CI_TWO;
        end else if (w_sum[1] >= w_sum[2] && w_sum[1] >= w_sum[3]
                     && w_sum[1] >= w_c0_div3) begin
            w_pref = CI_ONE;
        end else begin
            w_pref = CI_ZERO;
        end
        if (!w_done) begin
            w_pref = CI_ZERO;
        end
    end

    // Row offset: image width times pixel line, plus the tile's column.
    always_comb begin
        w_line   = {r_ty, 3'b000} + LINE_W'(r_row);
        w_prod   = PROD_W'(w_line) * PROD_W'(SIDE);
        w_offset = w_prod[OFFSET_W-1:0] + OFFSET_W'({r_tx, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_zero  <= COLOR_ZERO_RST;
            r_color_one   <= COLOR_ONE_RST;
            r_color_two   <= COLOR_TWO_RST;
            r_color_three <= COLOR_THREE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_COLOR_ZERO:  r_color_zero  <= i_cfg_data;
                CFG_COLOR_ONE:   r_color_one   <= i_cfg_data;
                CFG_COLOR_TWO:   r_color_two   <= i_cfg_data;
                CFG_COLOR_THREE: r_color_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= s_axis_tvalid;
            r_m_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && s_axis_tvalid) begin
            r_lo <= s_axis_tdata[7:0];
            r_hi <= s_axis_tdata[15:8];
        end
        if (w_work) begin
            r_tdata <= {r_tile, w_pref, w_offset, w_pixels};
            r_tlast <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_tile <= '0;
            r_tx   <= '0;
            r_ty   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_tally[k] <= '0;
            end
        end else if (w_work) begin
            r_row <= r_row + ROW_W'(1);
            if (w_done) begin
                for (int k = 0; k < 4; k++) begin
                    r_tally[k] <= '0;
                end
                r_tile <= r_tile + TILE_W'(1);
                // The tile number wraps at 256 regardless of the image width,
                // so the column and tile row restart with it.
                if (r_tile == {TILE_W{1'b1}}) begin
                    r_tx <= '0;
                    r_ty <= '0;
                end else if (r_tx == TX_W'(TILES_PER_SIDE - 1)) begin
                    r_tx <= '0;
                    r_ty <= r_ty + TILE_W'(1);
                end else begin
                    r_tx <= r_tx + TX_W'(1);
                end
            end else begin
                for (int k = 0; k < 4; k++) begin
                    r_tally[k] <= w_sum[k];
                end
            end
        end
    end

endmodule

// File: src/ptdd_checker.sv
// Port-level checker for the planar tile decoder, bound to its top level.
// Depends on ptdd_pkg and the assertion macro header.
`include "planar_tile_decode_dominant_color_macros.svh"

module ptdd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ptdd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                             m_axis_tlast
);
    import ptdd_pkg::*;

    logic              r_seen;
    logic              r_prev_last;
    logic [TILE_W-1:0] r_prev_tile;
    logic [TILE_W-1:0] w_tile;
    logic [TILE_W-1:0] w_expect_tile;

    assign w_tile        = m_axis_tdata[TILE_LSB +: TILE_W];
    assign w_expect_tile = r_prev_last ? r_prev_tile + TILE_W'(1) : r_prev_tile;

    // Remember the last delivered word so that the tile sequence can be followed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            r_prev_last <= m_axis_tlast;
            r_prev_tile <= w_tile;
        end
    end

    `PTDD_ASSERT_ALL(a_idle_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid)

    `PTDD_ASSERT_RST(a_stall_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    `PTDD_ASSERT_RST(a_pref_only_on_last, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[PREF_LSB +: 2] == 2'b00)

    `PTDD_ASSERT_RST(a_offset_aligned, i_clk, i_rst_n,
        m_axis_tvalid |-> m_axis_tdata[OFFSET_LSB +: 3] == 3'b000)

    `PTDD_ASSERT_RST(a_tile_sequence, i_clk, i_rst_n,
        m_axis_tvalid && r_seen |-> w_tile == w_expect_tile)

endmodule

bind planar_tile_decode_dominant_color ptdd_checker u_ptdd_checker (.*);
